// File: hdl/rpd_pkg.sv
package rpd_pkg;

    typedef enum logic [1:0] {
        OP_EDGE = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PPM   = 2'd1,
        KIND_PWM   = 2'd2,
        KIND_NOISY = 2'd3
    } t_kind;

    localparam logic [1:0] CFG_INVERT    = 2'd0;
    localparam logic [1:0] CFG_SYNC_THR  = 2'd1;
    localparam logic [1:0] CFG_STALE     = 2'd2;
    localparam logic [1:0] CFG_LINK_LOST = 2'd3;

    localparam logic [15:0] SYNC_THR_RST   = 16'd2700;
    localparam logic [15:0] STALE_RST      = 16'd500;
    localparam logic [15:0] LINK_LOST_RST  = 16'd1;
    localparam logic [31:0] MS_PER_S       = 32'd1000;
    localparam logic [31:0] LINK_LIMIT_RST = 32'd1000;

    localparam logic [31:0] PULSE_MIN_US = 32'd750;
    localparam logic [31:0] PULSE_MAX_US = 32'd2250;
    localparam logic [31:0] FRAME_MIN_CH = 32'd4;
    localparam logic [31:0] PPM_LOSS_MS  = 32'd250;
    localparam logic [31:0] PWM_FRESH_MS = 32'd80;
    localparam logic [15:0] INTERVAL_SAT = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic        pin_high;
        logic [31:0] now_us;
        logic [31:0] now_ms;
        logic [3:0]  channel_index;
    } t_item;

    typedef struct packed {
        logic [11:0] channel_width_us;
        t_kind       signal_kind;
        logic [31:0] frames_committed;
        logic [31:0] last_frame_time_ms;
        logic        channels_stale;
        logic        link_lost;
        logic [31:0] edges_seen;
        logic [31:0] syncs_seen;
        logic [31:0] good_pulses;
        logic [31:0] rejected_pulses;
        logic [15:0] last_interval_us;
        logic [11:0] last_pwm_high_us;
    } t_result;

endpackage

// File: hdl/rc_ppm_pwm_pulse_decoder.sv
// flow: a request accepted into the input register moves on into the result register
// throughput: one request per cycle while the result register is free or draining, set by
// the single update between the input register and the result register
// reset: synchronous active-low, clears handshake state, counters and published widths,
// and restores the configuration defaults
module rc_ppm_pwm_pulse_decoder
    import rpd_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic        i_pin_high,
    input  logic [31:0] i_now_us,
    input  logic [31:0] i_now_ms,
    input  logic [3:0]  i_channel_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_channel_width_us,
    output logic [1:0]  o_signal_kind,
    output logic [31:0] o_frames_committed,
    output logic [31:0] o_last_frame_time_ms,
    output logic        o_channels_stale,
    output logic        o_link_lost,
    output logic [31:0] o_edges_seen,
    output logic [31:0] o_syncs_seen,
    output logic [31:0] o_good_pulses,
    output logic [31:0] o_rejected_pulses,
    output logic [15:0] o_last_interval_us,
    output logic [11:0] o_last_pwm_high_us
);

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    advance;
    t_result next_result;
    t_result r_result;
    logic    r_out_valid;

    assign in_item.operation     = i_operation;
    assign in_item.pin_high      = i_pin_high;
    assign in_item.now_us        = i_now_us;
    assign in_item.now_ms        = i_now_ms;
    assign in_item.channel_index = i_channel_index;

    // the held request moves on whenever the result register is free or draining
    assign advance = stage_valid && (!r_out_valid || i_ready);

    rpd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .i_take  (advance),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    rpd_core #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (advance),
        .i_item      (stage_item),
        .o_result    (next_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= next_result;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_channel_width_us   = r_result.channel_width_us;
    assign o_signal_kind        = r_result.signal_kind;
    assign o_frames_committed   = r_result.frames_committed;
    assign o_last_frame_time_ms = r_result.last_frame_time_ms;
    assign o_channels_stale     = r_result.channels_stale;
    assign o_link_lost          = r_result.link_lost;
    assign o_edges_seen         = r_result.edges_seen;
    assign o_syncs_seen         = r_result.syncs_seen;
    assign o_good_pulses        = r_result.good_pulses;
    assign o_rejected_pulses    = r_result.rejected_pulses;
    assign o_last_interval_us   = r_result.last_interval_us;
    assign o_last_pwm_high_us   = r_result.last_pwm_high_us;

endmodule

// File: hdl/rpd_in_stage.sv
module rpd_in_stage
    import rpd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: hdl/rpd_core.sv
module rpd_core
    import rpd_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_fire,
    input  t_item       i_item,
    output t_result     o_result
);

    localparam int CNTW = $clog2(MAX_CHANNELS + 1);

    // configuration
    logic        r_invert;
    logic [15:0] r_sync_thr;
    logic [15:0] r_stale;
    logic [31:0] r_limit;

    // decoder state
    logic [11:0]     r_pub [MAX_CHANNELS];
    logic [11:0]     n_pub [MAX_CHANNELS];
    logic [11:0]     r_scr [MAX_CHANNELS];
    logic [11:0]     n_scr [MAX_CHANNELS];
    logic [CNTW-1:0] r_count, n_count;
    logic [31:0]     r_chan0, n_chan0;
    logic [31:0]     r_sample_time, n_sample_time;
    logic [31:0]     r_rise_time, n_rise_time;
    logic            r_rise_seen, n_rise_seen;
    logic [31:0]     r_frame_cnt, n_frame_cnt;
    logic [31:0]     r_frame_time, n_frame_time;
    logic [31:0]     r_last_edge, n_last_edge;
    t_kind           r_kind, n_kind;
    logic [15:0]     r_interval, n_interval;
    logic [11:0]     r_pwm_high, n_pwm_high;
    logic [31:0]     r_edges, n_edges;
    logic [31:0]     r_syncs, n_syncs;
    logic [31:0]     r_good, n_good;
    logic [31:0]     r_rej, n_rej;

    logic [31:0] high_time;
    logic [31:0] width;
    logic [31:0] age_frame;
    logic [31:0] age_chan0;
    logic [31:0] age_edge;
    logic [31:0] age;
    logic        high_ok;
    logic        width_ok;
    logic        sampled;
    logic        ppm_recent;
    logic        frame_ok;
    logic        committed;
    logic        pwm_published;

    assign high_time  = i_item.now_us - r_rise_time;
    assign width      = i_item.now_us - r_sample_time;
    assign age_frame  = i_item.now_ms - r_frame_time;
    assign age_chan0  = i_item.now_ms - r_chan0;
    assign age_edge   = i_item.now_ms - r_last_edge;
    assign high_ok    = (high_time >= PULSE_MIN_US) && (high_time <= PULSE_MAX_US);
    assign width_ok   = (width >= PULSE_MIN_US) && (width <= PULSE_MAX_US);
    assign sampled    = i_item.pin_high ^ r_invert;
    assign ppm_recent = (r_frame_cnt != 32'd0) && (age_frame <= PPM_LOSS_MS);
    assign frame_ok   = {{(32-CNTW){1'b0}}, r_count} >= FRAME_MIN_CH;

    always_comb begin
        n_pub         = r_pub;
        n_scr         = r_scr;
        n_count       = r_count;
        n_chan0       = r_chan0;
        n_sample_time = r_sample_time;
        n_rise_time   = r_rise_time;
        n_rise_seen   = r_rise_seen;
        n_frame_cnt   = r_frame_cnt;
        n_frame_time  = r_frame_time;
        n_last_edge   = r_last_edge;
        n_kind        = r_kind;
        n_interval    = r_interval;
        n_pwm_high    = r_pwm_high;
        n_edges       = r_edges;
        n_syncs       = r_syncs;
        n_good        = r_good;
        n_rej         = r_rej;
        committed     = 1'b0;
        pwm_published = 1'b0;

        if (i_fire) begin
            unique case (i_item.operation)
                OP_EDGE: begin
                    n_edges     = r_edges + 32'd1;
                    n_last_edge = i_item.now_ms;

                    // pwm high time fallback
                    if (i_item.pin_high) begin
                        n_rise_time = i_item.now_us;
                        n_rise_seen = 1'b1;
                    end else if (r_rise_seen) begin
                        n_rise_seen = 1'b0;
                        if (high_ok) begin
                            n_pwm_high = high_time[11:0];
                            if (!ppm_recent) begin
                                n_pub[0]      = high_time[11:0];
                                n_chan0       = i_item.now_ms;
                                n_kind        = KIND_PWM;
                                pwm_published = 1'b1;
                            end
                        end
                    end

                    // ppm interval on the sampled polarity
                    if (sampled) begin
                        n_sample_time = i_item.now_us;
                        if (r_sample_time != 32'd0) begin
                            n_interval = (|width[31:16]) ? INTERVAL_SAT : width[15:0];
                            if (width > {16'd0, r_sync_thr}) begin
                                n_syncs = r_syncs + 32'd1;
                                if (frame_ok) begin
                                    for (int i = 0; i < MAX_CHANNELS; i++) begin
                                        if (CNTW'(i) < r_count) begin
                                            n_pub[i] = r_scr[i];
                                        end
                                    end
                                    n_chan0      = i_item.now_ms;
                                    n_frame_cnt  = r_frame_cnt + 32'd1;
                                    n_frame_time = i_item.now_ms;
                                    n_kind       = KIND_PPM;
                                    committed    = 1'b1;
                                end
                                n_count = '0;
                            end else if (!width_ok) begin
                                n_rej = r_rej + 32'd1;
                                if (!ppm_recent) begin
                                    n_kind = KIND_NOISY;
                                end
                            end else begin
                                n_good = r_good + 32'd1;
                                // channels past the last slot are dropped
                                for (int i = 0; i < MAX_CHANNELS; i++) begin
                                    if (r_count == CNTW'(i)) begin
                                        n_scr[i] = width[11:0];
                                    end
                                end
                                if (r_count != CNTW'(MAX_CHANNELS)) begin
                                    n_count = r_count + CNTW'(1);
                                end
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (ppm_recent) begin
                        n_kind = KIND_PPM;
                    end else if ((r_chan0 != 32'd0) && (age_chan0 <= PWM_FRESH_MS)) begin
                        n_kind = KIND_PWM;
                    end else if ((r_last_edge != 32'd0) && (age_edge <= PWM_FRESH_MS)) begin
                        n_kind = KIND_NOISY;
                    end else begin
                        n_kind = KIND_NONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // a fresh commit stamps now, so its age is zero; a pwm publish does too while no frame is committed
    always_comb begin
        if (committed) begin
            age = 32'd0;
        end else if (r_frame_cnt != 32'd0) begin
            age = age_frame;
        end else if (pwm_published) begin
            age = 32'd0;
        end else begin
            age = age_chan0;
        end
    end

    always_comb begin
        o_result.channel_width_us = 12'd0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (i_item.channel_index == 4'(i)) begin
                o_result.channel_width_us = n_pub[i];
            end
        end
        o_result.signal_kind        = n_kind;
        o_result.frames_committed   = n_frame_cnt;
        o_result.last_frame_time_ms = n_frame_time;
        o_result.channels_stale     = age > {16'd0, r_stale};
        o_result.link_lost          = age >= r_limit;
        o_result.edges_seen         = n_edges;
        o_result.syncs_seen         = n_syncs;
        o_result.good_pulses        = n_good;
        o_result.rejected_pulses    = n_rej;
        o_result.last_interval_us   = n_interval;
        o_result.last_pwm_high_us   = n_pwm_high;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert   <= 1'b0;
            r_sync_thr <= SYNC_THR_RST;
            r_stale    <= STALE_RST;
            r_limit    <= LINK_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_INVERT:    r_invert   <= i_cfg_data[0];
                CFG_SYNC_THR:  r_sync_thr <= i_cfg_data;
                CFG_STALE:     r_stale    <= i_cfg_data;
                CFG_LINK_LOST: r_limit    <= {16'd0, i_cfg_data} * MS_PER_S;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_pub[i] <= 12'd0;
            end
            r_count       <= '0;
            r_chan0       <= 32'd0;
            r_sample_time <= 32'd0;
            r_rise_time   <= 32'd0;
            r_rise_seen   <= 1'b0;
            r_frame_cnt   <= 32'd0;
            r_frame_time  <= 32'd0;
            r_last_edge   <= 32'd0;
            r_kind        <= KIND_NONE;
            r_interval    <= 16'd0;
            r_pwm_high    <= 12'd0;
            r_edges       <= 32'd0;
            r_syncs       <= 32'd0;
            r_good        <= 32'd0;
            r_rej         <= 32'd0;
        end else begin
            r_pub         <= n_pub;
            r_count       <= n_count;
            r_chan0       <= n_chan0;
            r_sample_time <= n_sample_time;
            r_rise_time   <= n_rise_time;
            r_rise_seen   <= n_rise_seen;
            r_frame_cnt   <= n_frame_cnt;
            r_frame_time  <= n_frame_time;
            r_last_edge   <= n_last_edge;
            r_kind        <= n_kind;
            r_interval    <= n_interval;
            r_pwm_high    <= n_pwm_high;
            r_edges       <= n_edges;
            r_syncs       <= n_syncs;
            r_good        <= n_good;
            r_rej         <= n_rej;
        end
    end

    // scratch frame is not reset; a commit publishes only the entries the current frame has written
    always_ff @(posedge i_clk) begin
        r_scr <= n_scr;
    end

endmodule

// File: verif/rc_ppm_pwm_pulse_decoder_tb.sv
`timescale 1ns / 100ps

module rc_ppm_pwm_pulse_decoder_tb;
    import rpd_pkg::*;

    localparam int          MAX_CH      = 8;
    localparam int          CH_IDX_W    = $clog2(MAX_CH);
    localparam logic [1:0]  OP_RESERVED = 2'd3;
    localparam int unsigned STUCK_LIMIT = 5000;
    localparam int unsigned PRINT_LIMIT = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = '0;
    logic        i_pin_high = 1'b0;
    logic [31:0] i_now_us = '0;
    logic [31:0] i_now_ms = '0;
    logic [3:0]  i_channel_index = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [11:0] o_channel_width_us;
    logic [1:0]  o_signal_kind;
    logic [31:0] o_frames_committed;
    logic [31:0] o_last_frame_time_ms;
    logic        o_channels_stale;
    logic        o_link_lost;
    logic [31:0] o_edges_seen;
    logic [31:0] o_syncs_seen;
    logic [31:0] o_good_pulses;
    logic [31:0] o_rejected_pulses;
    logic [15:0] o_last_interval_us;
    logic [11:0] o_last_pwm_high_us;

    rc_ppm_pwm_pulse_decoder #(
        .MAX_CHANNELS(MAX_CH)
    ) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_operation          (i_operation),
        .i_pin_high           (i_pin_high),
        .i_now_us             (i_now_us),
        .i_now_ms             (i_now_ms),
        .i_channel_index      (i_channel_index),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_channel_width_us   (o_channel_width_us),
        .o_signal_kind        (o_signal_kind),
        .o_frames_committed   (o_frames_committed),
        .o_last_frame_time_ms (o_last_frame_time_ms),
        .o_channels_stale     (o_channels_stale),
        .o_link_lost          (o_link_lost),
        .o_edges_seen         (o_edges_seen),
        .o_syncs_seen         (o_syncs_seen),
        .o_good_pulses        (o_good_pulses),
        .o_rejected_pulses    (o_rejected_pulses),
        .o_last_interval_us   (o_last_interval_us),
        .o_last_pwm_high_us   (o_last_pwm_high_us)
    );

    always #6 i_clk = ~i_clk;

    // decoder state as the block should hold it
    logic        cfg_invert = 1'b0;
    logic [15:0] cfg_sync_thr = SYNC_THR_RST;
    logic [15:0] cfg_stale = STALE_RST;
    logic [15:0] cfg_link = LINK_LOST_RST;

    logic [11:0] pub_width [MAX_CH] = '{default: '0};
    logic [11:0] scratch_width [MAX_CH] = '{default: '0};
    logic [3:0]  scratch_fill = '0;
    logic [31:0] chan0_ms = '0;
    logic [31:0] sample_us = '0;
    logic [31:0] rise_us = '0;
    logic        rise_pending = 1'b0;
    logic [31:0] frames_total = '0;
    logic [31:0] frame_ms = '0;
    logic [31:0] last_edge_ms = '0;
    t_kind       kind_now = KIND_NONE;
    logic [15:0] interval_now = '0;
    logic [11:0] pwm_high_now = '0;
    logic [31:0] n_edges = '0;
    logic [31:0] n_syncs = '0;
    logic [31:0] n_good = '0;
    logic [31:0] n_rejected = '0;

    t_item       pending_requests [$];
    t_result     expected_status [$];
    t_item       cur_req;

    int unsigned queued_total = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned stuck_cycles = 0;

    // stimulus time base
    logic [31:0] tb_us = '0;
    logic [31:0] tb_ms = '0;
    longint      ms_carry = 0;
    int unsigned ppm_gap = 3000;
    logic        phase_invert = 1'b0;
    logic [15:0] phase_thr = SYNC_THR_RST;

    function automatic logic ppm_recent(input logic [31:0] now_ms);
        return frames_total != 0 && (now_ms - frame_ms) <= PPM_LOSS_MS;
    endfunction

    function automatic t_result decode_request(input t_item req);
        t_result     res;
        logic [31:0] span;
        logic [31:0] high_time;
        logic [31:0] age;
        logic [31:0] link_limit;
        if (req.operation == OP_EDGE) begin
            n_edges++;
            last_edge_ms = req.now_ms;
            if (req.pin_high) begin
                rise_us = req.now_us;
                rise_pending = 1'b1;
            end else if (rise_pending) begin
                high_time = req.now_us - rise_us;
                rise_pending = 1'b0;
                if (high_time >= PULSE_MIN_US && high_time <= PULSE_MAX_US) begin
                    pwm_high_now = high_time[11:0];
                    // pwm fallback only once ppm has lapsed
                    if (!ppm_recent(req.now_ms)) begin
                        pub_width[0] = high_time[11:0];
                        chan0_ms = req.now_ms;
                        kind_now = KIND_PWM;
                    end
                end
            end
            if (req.pin_high != cfg_invert) begin
                // a zero stamp means no sampled edge yet
                if (sample_us == '0) begin
                    sample_us = req.now_us;
                end else begin
                    span = req.now_us - sample_us;
                    sample_us = req.now_us;
                    interval_now = (span > 32'h0000_FFFF) ? INTERVAL_SAT : span[15:0];
                    if (span > {16'd0, cfg_sync_thr}) begin
                        n_syncs++;
                        if (scratch_fill >= FRAME_MIN_CH) begin
                            for (int i = 0; i < MAX_CH; i++) begin
                                if (i < scratch_fill) begin
                                    pub_width[i] = scratch_width[i];
                                end
                            end
                            chan0_ms = req.now_ms;
                            frames_total++;
                            frame_ms = req.now_ms;
                            kind_now = KIND_PPM;
                        end
                        scratch_fill = '0;
                    end else if (span < PULSE_MIN_US || span > PULSE_MAX_US) begin
                        n_rejected++;
                        if (!ppm_recent(req.now_ms)) begin
                            kind_now = KIND_NOISY;
                        end
                    end else begin
                        n_good++;
                        if (scratch_fill < MAX_CH) begin
                            scratch_width[scratch_fill[CH_IDX_W-1:0]] = span[11:0];
                            scratch_fill++;
                        end
                    end
                end
            end
        end else if (req.operation == OP_TICK) begin
            if (ppm_recent(req.now_ms)) begin
                kind_now = KIND_PPM;
            end else if (chan0_ms != '0 && (req.now_ms - chan0_ms) <= PWM_FRESH_MS) begin
                kind_now = KIND_PWM;
            end else if (last_edge_ms != '0
                         && (req.now_ms - last_edge_ms) <= PWM_FRESH_MS) begin
                kind_now = KIND_NOISY;
            end else begin
                kind_now = KIND_NONE;
            end
        end

        age = req.now_ms - ((frames_total != '0) ? frame_ms : chan0_ms);
        link_limit = {16'd0, cfg_link} * MS_PER_S;

        res.channel_width_us   = (req.channel_index < MAX_CH) ?
                                 pub_width[req.channel_index[CH_IDX_W-1:0]] : '0;
        res.signal_kind        = kind_now;
        res.frames_committed   = frames_total;
        res.last_frame_time_ms = frame_ms;
        res.channels_stale     = age > {16'd0, cfg_stale};
        res.link_lost          = age >= link_limit;
        res.edges_seen         = n_edges;
        res.syncs_seen         = n_syncs;
        res.good_pulses        = n_good;
        res.rejected_pulses    = n_rejected;
        res.last_interval_us   = interval_now;
        res.last_pwm_high_us   = pwm_high_now;
        return res;
    endfunction

    task automatic report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("result %0d %s: got %0d, expected %0d",
                                   results_seen, name, got, want));
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_status.push_back(decode_request(cur_req));
            end
            if (!i_valid || o_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = pending_requests.pop_front();
                    i_operation     <= cur_req.operation;
                    i_pin_high      <= cur_req.pin_high;
                    i_now_us        <= cur_req.now_us;
                    i_now_ms        <= cur_req.now_ms;
                    i_channel_index <= cur_req.channel_index;
                    i_valid         <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_status.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing expected",
                                           results_seen));
                end else begin
                    want = expected_status.pop_front();
                    check_field("channel_width_us", o_channel_width_us,
                                want.channel_width_us);
                    check_field("signal_kind", o_signal_kind, want.signal_kind);
                    check_field("frames_committed", o_frames_committed,
                                want.frames_committed);
                    check_field("last_frame_time_ms", o_last_frame_time_ms,
                                want.last_frame_time_ms);
                    check_field("channels_stale", o_channels_stale, want.channels_stale);
                    check_field("link_lost", o_link_lost, want.link_lost);
                    check_field("edges_seen", o_edges_seen, want.edges_seen);
                    check_field("syncs_seen", o_syncs_seen, want.syncs_seen);
                    check_field("good_pulses", o_good_pulses, want.good_pulses);
                    check_field("rejected_pulses", o_rejected_pulses,
                                want.rejected_pulses);
                    check_field("last_interval_us", o_last_interval_us,
                                want.last_interval_us);
                    check_field("last_pwm_high_us", o_last_pwm_high_us,
                                want.last_pwm_high_us);
                end
                results_seen++;
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stuck_cycles <= 0;
        end else if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_status.size());
            $display("FAILURE");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic push_req(input logic [1:0] op, input logic level, input logic [31:0] us,
                            input logic [31:0] ms, input logic [3:0] chan);
        t_item req;
        req.operation     = op;
        req.pin_high      = level;
        req.now_us        = us;
        req.now_ms        = ms;
        req.channel_index = chan;
        pending_requests.push_back(req);
        if (op == OP_EDGE || op == OP_TICK) begin
            queued_total++;
        end
    endtask

    task automatic step_time(input int unsigned gap_us);
        tb_us += gap_us;
        ms_carry += gap_us;
        tb_ms += 32'(ms_carry / 1000);
        ms_carry %= 1000;
    endtask

    task automatic pin_edge(input logic level, input int unsigned gap_us);
        step_time(gap_us);
        push_req(OP_EDGE, level, tb_us, tb_ms, 4'($urandom_range(15)));
    endtask

    task automatic status_probe();
        int unsigned pick;
        logic [1:0]  op;
        logic [31:0] ms;
        pick = $urandom_range(99);
        if (pick < 60) begin
            op = OP_TICK;
        end else if (pick < 90) begin
            op = OP_READ;
        end else begin
            op = OP_RESERVED;
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            ms = tb_ms;
        end else if (pick < 90) begin
            ms = tb_ms + $urandom_range(1500);
        end else begin
            ms = $urandom;
        end
        push_req(op, 1'($urandom_range(1)), tb_us, ms, 4'($urandom_range(15)));
    endtask

    // one frame: per channel a sampled edge, a short pulse, then the gap to the next sampled edge
    task automatic ppm_frame(input logic samp);
        int unsigned pick;
        int unsigned n_ch;
        int unsigned pulse_us;
        int unsigned width;
        pick = $urandom_range(99);
        if (pick < 15) begin
            n_ch = $urandom_range(3);
        end else if (pick < 25) begin
            n_ch = $urandom_range(12, 9);
        end else begin
            n_ch = $urandom_range(8, 4);
        end
        pulse_us = $urandom_range(400, 200);
        for (int unsigned i = 0; i <= n_ch; i++) begin
            pin_edge(samp, ppm_gap);
            pin_edge(!samp, pulse_us);
            pick = $urandom_range(99);
            if (i == n_ch) begin
                width = phase_thr + $urandom_range(8000, 1);
            end else if (pick < 5) begin
                width = PULSE_MIN_US;
            end else if (pick < 10) begin
                width = PULSE_MAX_US;
            end else if (pick < 15) begin
                width = $urandom_range(749, 500);
            end else if (pick < 20) begin
                width = $urandom_range(3000, 2251);
            end else begin
                width = $urandom_range(2250, 750);
            end
            ppm_gap = width - pulse_us;
        end
        if ($urandom_range(3) == 0) begin
            status_probe();
        end
    endtask

    task automatic random_traffic(input int unsigned n_items);
        int unsigned goal;
        int unsigned pick;
        int unsigned high_us;
        goal = queued_total + n_items;
        while (queued_total < goal) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                ppm_frame(!phase_invert);
            end else if (pick < 50) begin
                // frame on the wrong polarity
                ppm_frame(phase_invert);
            end else if (pick < 62) begin
                // let ppm lapse so the pwm fallback can publish
                if ($urandom_range(1) == 1) begin
                    step_time(300_000);
                end
                repeat ($urandom_range(6, 1)) begin
                    pick = $urandom_range(99);
                    if (pick < 5) begin
                        high_us = PULSE_MIN_US;
                    end else if (pick < 10) begin
                        high_us = PULSE_MAX_US;
                    end else if (pick < 20) begin
                        high_us = $urandom_range(749, 100);
                    end else if (pick < 30) begin
                        high_us = $urandom_range(4000, 2251);
                    end else begin
                        high_us = $urandom_range(2250, 750);
                    end
                    pin_edge(1'b1, $urandom_range(20000, 2000));
                    pin_edge(1'b0, high_us);
                end
            end else if (pick < 70) begin
                repeat ($urandom_range(8, 1)) begin
                    pin_edge(1'($urandom_range(1)), ($urandom_range(9) == 0) ?
                             $urandom_range(1 << 20) : $urandom_range(5000));
                end
            end else if (pick < 88) begin
                status_probe();
            end else begin
                if ($urandom_range(9) == 0) begin
                    step_time($urandom);
                end else begin
                    step_time($urandom_range(1_500_000, 50_000));
                end
                status_probe();
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || i_valid || expected_status.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_INVERT:   cfg_invert = value[0];
            CFG_SYNC_THR: cfg_sync_thr = value;
            CFG_STALE:    cfg_stale = value;
            default:      cfg_link = value;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic inv, input logic [15:0] thr, input logic [15:0] stale,
                             input logic [15:0] link, input int unsigned send_pct,
                             input int unsigned recv_pct, input int unsigned n_items,
                             input bit pause_midway);
        wait_idle();
        write_reg(CFG_INVERT, {15'($urandom), inv});
        write_reg(CFG_SYNC_THR, thr);
        write_reg(CFG_STALE, stale);
        write_reg(CFG_LINK_LOST, link);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        phase_invert   = inv;
        phase_thr      = thr;
        tb_us          = $urandom;
        tb_ms          = $urandom;
        if (pause_midway) begin
            random_traffic(n_items / 2);
            // hold off new requests until every result is back
            wait_idle();
            random_traffic(n_items - n_items / 2);
        end else begin
            random_traffic(n_items);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening under reset configuration
        push_req(OP_READ, 1'b0, 32'd0, 32'd0, 4'd15);
        push_req(OP_RESERVED, 1'b1, '1, '1, 4'd0);
        push_req(OP_TICK, 1'b0, 32'd0, 32'd0, 4'd1);
        // sampled edge at time zero only restarts the measurement
        push_req(OP_EDGE, 1'b1, 32'd0, 32'd1, 4'd0);
        push_req(OP_EDGE, 1'b0, 32'd1500, 32'd2, 4'd0);
        push_req(OP_EDGE, 1'b1, 32'd5000, 32'd5, 4'd2);
        push_req(OP_EDGE, 1'b0, 32'd5300, 32'd5, 4'd3);
        push_req(OP_EDGE, 1'b1, 32'd5750, 32'd5, 4'd0);
        push_req(OP_EDGE, 1'b1, 32'd8000, 32'd8, 4'd1);
        push_req(OP_EDGE, 1'b1, 32'd9500, 32'd9, 4'd2);
        push_req(OP_EDGE, 1'b1, 32'd10500, 32'd10, 4'd3);
        // just over the threshold: four channels committed
        push_req(OP_EDGE, 1'b1, 32'd13201, 32'd13, 4'd3);
        push_req(OP_EDGE, 1'b1, 32'd14951, 32'd14, 4'd4);
        push_req(OP_EDGE, 1'b1, 32'd15951, 32'd15, 4'd5);
        push_req(OP_EDGE, 1'b1, 32'd16951, 32'd16, 4'd6);
        // equal to the threshold is not a sync
        push_req(OP_EDGE, 1'b1, 32'd19651, 32'd19, 4'd7);
        // second frame is too short to commit, then intervals just outside the range are rejected
        push_req(OP_EDGE, 1'b1, 32'd22352, 32'd22, 4'd8);
        push_req(OP_EDGE, 1'b1, 32'd23101, 32'd23, 4'd9);
        push_req(OP_EDGE, 1'b1, 32'd25352, 32'd25, 4'd10);
        push_req(OP_TICK, 1'b1, 32'd25352, 32'd300, 4'd0);
        // empty frame at the sync is dropped
        push_req(OP_EDGE, 1'b1, 32'd125352, 32'd400, 4'd11);
        push_req(OP_EDGE, 1'b0, 32'd127602, 32'd402, 4'd0);
        push_req(OP_EDGE, 1'b1, 32'hFFFF_FF00, 32'd2000, 4'd12);
        push_req(OP_EDGE, 1'b1, 32'h0000_02EE, 32'd2001, 4'd13);
        push_req(OP_READ, 1'b0, 32'h0000_02EE, 32'd1500, 4'd14);

        run_phase(1'b0, SYNC_THR_RST, STALE_RST, LINK_LOST_RST, 0, 0, 300, 1'b0);
        run_phase(1'b1, 16'd3000, 16'd100, 16'd2, 75, 0, 300, 1'b0);
        run_phase(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 75, 300, 1'b0);
        run_phase(1'b1, 16'd0, 16'd0, 16'd0, 11, 11, 150, 1'b0);
        run_phase(1'b0, 16'd2000, 16'($urandom), 16'd1, 0, 0, 300, 1'b1);
        run_phase(1'($urandom_range(1)), 16'($urandom_range(6000, 2300)),
                  16'($urandom_range(2000)), 16'($urandom_range(3)), 11, 11, 400, 1'b0);

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/rpd_pkg.sv
hdl/rpd_in_stage.sv
hdl/rpd_core.sv
hdl/rc_ppm_pwm_pulse_decoder.sv
verif/rc_ppm_pwm_pulse_decoder_tb.sv
